>>> hw/rtl/lwfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwfc_pkg
// Types and constants shared by the wall follow controller core.
// ----------------------------------------------------------------------------
package lwfc_pkg;

  // opcodes of an input item
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // register indexes
  localparam logic [2:0] REG_LEFT_START   = 3'd0;
  localparam logic [2:0] REG_LEFT_END     = 3'd1;
  localparam logic [2:0] REG_CENTER_START = 3'd2;
  localparam logic [2:0] REG_CENTER_END   = 3'd3;
  localparam logic [2:0] REG_RIGHT_START  = 3'd4;
  localparam logic [2:0] REG_RIGHT_END    = 3'd5;
  localparam logic [2:0] REG_NEAR_LIMIT   = 3'd6;
  localparam logic [2:0] REG_FOLLOW_LIMIT = 3'd7;

  localparam int CFG_AW = 5;

  // controller constants
  localparam logic [16:0]        MAX_SAMPLES   = 17'd1024;
  localparam logic [6:0]         LOST_LIMIT    = 7'd50;
  localparam logic [6:0]         LOST_SAT      = 7'd127;
  localparam logic [15:0]        FAR_MM        = 16'd1500;
  localparam logic [9:0]         FORWARD_SPEED = 10'd600;
  localparam logic [9:0]         SLOW_SPEED    = 10'd200;
  localparam logic signed [10:0] TURN_RATE     = 11'sd1000;
  localparam logic [15:0]        RANGE_MAX     = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_FWD    = 2'd0,
    MODE_TOWARD = 2'd1,
    MODE_AWAY   = 2'd2
  } mode_t;

  typedef struct packed {
    logic        opcode;
    logic [9:0]  sample_index;
    logic [15:0] range_mm;
    logic        last_sample;
    logic        tie_side;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         linear_mm_s;
    logic signed [10:0] angular_mrad_s;
    logic               wall_known;
    logic [1:0]         motion_mode;
  } out_item_t;

  typedef struct packed {
    logic [9:0]  left_start;
    logic [9:0]  left_end;
    logic [9:0]  center_start;
    logic [9:0]  center_end;
    logic [9:0]  right_start;
    logic [9:0]  right_end;
    logic [15:0] near_limit;
    logic [15:0] follow_limit;
  } cfg_t;

endpackage

>>> hw/rtl/lwfc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwfc_in_if / lwfc_out_if
// Valid/ready item channels for scan samples, ticks and speed commands.
// ----------------------------------------------------------------------------
interface lwfc_in_if
  import lwfc_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lwfc_out_if
  import lwfc_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/lwfc_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwfc_regs
// APB-style register file for window bounds and distance limits.
// ----------------------------------------------------------------------------
module lwfc_regs
  import lwfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg     = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left_start   <= 10'd0;
      cfg_r.left_end     <= 10'd0;
      cfg_r.center_start <= 10'd0;
      cfg_r.center_end   <= 10'd0;
      cfg_r.right_start  <= 10'd0;
      cfg_r.right_end    <= 10'd0;
      cfg_r.near_limit   <= 16'd400;
      cfg_r.follow_limit <= 16'd500;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LEFT_START:   cfg_r.left_start   <= pwdata[9:0];
        REG_LEFT_END:     cfg_r.left_end     <= pwdata[9:0];
        REG_CENTER_START: cfg_r.center_start <= pwdata[9:0];
        REG_CENTER_END:   cfg_r.center_end   <= pwdata[9:0];
        REG_RIGHT_START:  cfg_r.right_start  <= pwdata[9:0];
        REG_RIGHT_END:    cfg_r.right_end    <= pwdata[9:0];
        REG_NEAR_LIMIT:   cfg_r.near_limit   <= pwdata[15:0];
        REG_FOLLOW_LIMIT: cfg_r.follow_limit <= pwdata[15:0];
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_LEFT_START:   prdata = {22'd0, cfg_r.left_start};
      REG_LEFT_END:     prdata = {22'd0, cfg_r.left_end};
      REG_CENTER_START: prdata = {22'd0, cfg_r.center_start};
      REG_CENTER_END:   prdata = {22'd0, cfg_r.center_end};
      REG_RIGHT_START:  prdata = {22'd0, cfg_r.right_start};
      REG_RIGHT_END:    prdata = {22'd0, cfg_r.right_end};
      REG_NEAR_LIMIT:   prdata = {16'd0, cfg_r.near_limit};
      REG_FOLLOW_LIMIT: prdata = {16'd0, cfg_r.follow_limit};
    endcase
  end

endmodule

>>> hw/rtl/laser_wall_follow_controller_core.sv
`timescale 1ns / 1ps
// path: an item is registered in the input register on entry; a tick with
//   valid regions has its command registered in the output register on advance
// throughput: one item per cycle unless out is stalled, set by the single-pass
//   update of the window minima and follow state between input and output regs
// reset: synchronous active low; minima and regions read 65535, no side chosen
// ----------------------------------------------------------------------------
// laser_wall_follow_controller_core
// Scan window minima and follow speed commands, one item per cycle when unstalled.
// ----------------------------------------------------------------------------
module laser_wall_follow_controller_core
  import lwfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  lwfc_in_if.sink           in_ch,
  lwfc_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  cfg_t cfg;

  lwfc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // pipeline control
  in_item_t  s1_item_r;
  logic      s1_v_r;
  logic      out_v_r;
  out_item_t out_item_r;
  logic      accept;
  logic      adv;
  logic      has_res;

  // controller state
  logic [15:0] run_l_r, run_c_r, run_r_r;
  logic [15:0] run_l_nxt, run_c_nxt, run_r_nxt;
  logic [15:0] reg_l_r, reg_c_r, reg_r_r;
  logic [15:0] reg_l_nxt, reg_c_nxt, reg_r_nxt;
  logic        regions_valid_r, regions_valid_nxt;
  logic        side_chosen_r, side_chosen_nxt;
  logic        follow_side_r, follow_side_nxt;
  logic        wall_present_r, wall_present_nxt;
  mode_t       mode_r, mode_nxt;
  logic [6:0]  lost_r, lost_nxt;

  out_item_t          res;
  logic               idx_ok;
  logic               hit_l, hit_c, hit_r;
  logic [15:0]        min_l, min_c, min_r;
  logic [15:0]        side_dist;
  logic signed [10:0] toward_rate;

  assign has_res      = (s1_item_r.opcode == OP_TICK) && regions_valid_r;
  assign adv          = s1_v_r && (!has_res || !out_v_r || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || adv;
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_item_r;

  // window hits and running minima for a sample
  assign idx_ok = {7'd0, s1_item_r.sample_index} < MAX_SAMPLES;
  assign hit_l  = idx_ok && (s1_item_r.sample_index >= cfg.left_start)
                  && (s1_item_r.sample_index < cfg.left_end);
  assign hit_c  = idx_ok && (s1_item_r.sample_index >= cfg.center_start)
                  && (s1_item_r.sample_index < cfg.center_end);
  assign hit_r  = idx_ok && (s1_item_r.sample_index >= cfg.right_start)
                  && (s1_item_r.sample_index < cfg.right_end);
  assign min_l  = (hit_l && (s1_item_r.range_mm < run_l_r)) ? s1_item_r.range_mm : run_l_r;
  assign min_c  = (hit_c && (s1_item_r.range_mm < run_c_r)) ? s1_item_r.range_mm : run_c_r;
  assign min_r  = (hit_r && (s1_item_r.range_mm < run_r_r)) ? s1_item_r.range_mm : run_r_r;

  // next state and command for the item in the input register
  always_comb begin
    run_l_nxt         = run_l_r;
    run_c_nxt         = run_c_r;
    run_r_nxt         = run_r_r;
    reg_l_nxt         = reg_l_r;
    reg_c_nxt         = reg_c_r;
    reg_r_nxt         = reg_r_r;
    regions_valid_nxt = regions_valid_r;
    side_chosen_nxt   = side_chosen_r;
    follow_side_nxt   = follow_side_r;
    wall_present_nxt  = wall_present_r;
    mode_nxt          = mode_r;
    lost_nxt          = lost_r;
    res               = '0;
    side_dist         = reg_l_r;
    toward_rate       = TURN_RATE;

    if (s1_item_r.opcode == OP_SAMPLE) begin
      if (s1_item_r.last_sample) begin
        reg_l_nxt         = min_l;
        reg_c_nxt         = min_c;
        reg_r_nxt         = min_r;
        regions_valid_nxt = 1'b1;
        run_l_nxt         = RANGE_MAX;
        run_c_nxt         = RANGE_MAX;
        run_r_nxt         = RANGE_MAX;
      end else begin
        run_l_nxt = min_l;
        run_c_nxt = min_c;
        run_r_nxt = min_r;
      end
    end else if (regions_valid_r) begin
      // first tick picks the side
      if (!side_chosen_r) begin
        side_chosen_nxt  = 1'b1;
        wall_present_nxt = 1'b0;
        lost_nxt         = 7'd0;
        priority if (reg_l_r < cfg.follow_limit) begin
          follow_side_nxt  = 1'b0;
          wall_present_nxt = 1'b1;
        end else if (reg_r_r < cfg.follow_limit) begin
          follow_side_nxt  = 1'b1;
          wall_present_nxt = 1'b1;
        end else begin
          follow_side_nxt = s1_item_r.tie_side;
        end
      end

      if (!wall_present_nxt) begin
        // searching
        if ((reg_l_r < cfg.follow_limit) || (reg_c_r < cfg.follow_limit)
            || (reg_r_r < cfg.follow_limit)) begin
          wall_present_nxt = 1'b1;
          lost_nxt         = 7'd0;
        end
        res.linear_mm_s    = FORWARD_SPEED;
        res.angular_mrad_s = 11'sd0;
        res.wall_known     = 1'b0;
        res.motion_mode    = MODE_FWD;
      end else begin
        // following
        side_dist   = follow_side_nxt ? reg_r_r : reg_l_r;
        toward_rate = follow_side_nxt ? -TURN_RATE : TURN_RATE;
        priority if ((side_dist < cfg.near_limit) || (reg_c_r < cfg.near_limit)) begin
          mode_nxt = MODE_AWAY;
        end else if ((side_dist > cfg.follow_limit) && (reg_c_r > cfg.near_limit)) begin
          mode_nxt = MODE_TOWARD;
          if ((side_dist > FAR_MM) && (reg_c_r > FAR_MM)) begin
            if (lost_nxt > LOST_LIMIT) begin
              wall_present_nxt = 1'b0;
            end
            if (lost_nxt < LOST_SAT) begin
              lost_nxt = lost_nxt + 7'd1;
            end
          end
        end else if ((side_dist < cfg.follow_limit) && (reg_c_r > cfg.near_limit)) begin
          mode_nxt = MODE_FWD;
        end else begin
          mode_nxt = mode_r;
        end
        if (mode_nxt != MODE_TOWARD) begin
          lost_nxt = 7'd0;
        end

        res.wall_known  = 1'b1;
        res.motion_mode = mode_nxt;
        unique case (mode_nxt)
          MODE_TOWARD: begin
            res.linear_mm_s    = SLOW_SPEED;
            res.angular_mrad_s = toward_rate;
          end
          MODE_AWAY: begin
            res.linear_mm_s    = 10'd0;
            res.angular_mrad_s = -toward_rate;
          end
          default: begin
            res.linear_mm_s    = FORWARD_SPEED;
            res.angular_mrad_s = 11'sd0;
          end
        endcase
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_ch.data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && has_res) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && has_res) begin
      out_item_r <= res;
    end
  end

  // controller state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_l_r         <= RANGE_MAX;
      run_c_r         <= RANGE_MAX;
      run_r_r         <= RANGE_MAX;
      reg_l_r         <= RANGE_MAX;
      reg_c_r         <= RANGE_MAX;
      reg_r_r         <= RANGE_MAX;
      regions_valid_r <= 1'b0;
      side_chosen_r   <= 1'b0;
      follow_side_r   <= 1'b1;
      wall_present_r  <= 1'b0;
      mode_r          <= MODE_FWD;
      lost_r          <= 7'd0;
    end else if (adv) begin
      run_l_r         <= run_l_nxt;
      run_c_r         <= run_c_nxt;
      run_r_r         <= run_r_nxt;
      reg_l_r         <= reg_l_nxt;
      reg_c_r         <= reg_c_nxt;
      reg_r_r         <= reg_r_nxt;
      regions_valid_r <= regions_valid_nxt;
      side_chosen_r   <= side_chosen_nxt;
      follow_side_r   <= follow_side_nxt;
      wall_present_r  <= wall_present_nxt;
      mode_r          <= mode_nxt;
      lost_r          <= lost_nxt;
    end
  end

`ifndef SYNTHESIS
  // a nonzero lost count only builds up while turning toward the wall
  a_lost_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (lost_r != 7'd0) |-> (mode_r == MODE_TOWARD))
    else $error("lost count set outside turn toward mode");

  // a side is only chosen once a full scan has been seen
  a_side_regions: assert property (@(posedge clk) disable iff (!rst_n)
    side_chosen_r |-> regions_valid_r)
    else $error("side chosen without valid regions");

  // searching commands drive straight ahead
  a_search_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_item_r.wall_known) |->
      ((out_item_r.motion_mode == MODE_FWD) && (out_item_r.angular_mrad_s == 11'sd0)
       && (out_item_r.linear_mm_s == FORWARD_SPEED)))
    else $error("search command is not forward");

  // a command is only produced once a side has been chosen
  a_out_side: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && has_res) |=> side_chosen_r)
    else $error("command issued before side choice");
`endif

endmodule
